[rtl/rtsc_pkg.sv]
// Shared types, codes and helpers for the remote task session client.
package rtsc_pkg;

   // Event codes of a request
   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_HEARTBEAT = 3'd1;
   localparam logic [2:0] CMD_STATUS    = 3'd2;
   localparam logic [2:0] CMD_BAD_FRAME = 3'd3;
   localparam logic [2:0] CMD_START     = 3'd4;
   localparam logic [2:0] CMD_POLL      = 3'd5;
   localparam logic [2:0] CMD_CANCEL    = 3'd6;
   localparam logic [2:0] CMD_TAKE_FAIL = 3'd7;

   // Task step states
   localparam logic [2:0] ST_NOT_STARTED = 3'd0;
   localparam logic [2:0] ST_RUNNING     = 3'd1;
   localparam logic [2:0] ST_SUCCEEDED   = 3'd2;
   localparam logic [2:0] ST_FAILED      = 3'd3;
   localparam logic [2:0] ST_CANCELLED   = 3'd4;

   // Failure codes
   localparam logic [3:0] FL_NONE         = 4'd0;
   localparam logic [3:0] FL_PEER_RESET   = 4'd1;
   localparam logic [3:0] FL_LINK_TIMEOUT = 4'd2;
   localparam logic [3:0] FL_PROTOCOL     = 4'd3;

   // Command kinds on the wire
   localparam logic KIND_START  = 1'b0;
   localparam logic KIND_CANCEL = 1'b1;

   // Highest accepted action code
   localparam logic [2:0] ACT_MAX = 3'd1;

   // Control register indexes and reset values
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_SESSION  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HB_INTERVAL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_TIMEOUT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_INTVL  = 2'd3;
   localparam logic [31:0] RST_OWN_SESSION  = 32'd1;
   localparam logic [31:0] RST_HB_INTERVAL  = 32'd100;
   localparam logic [31:0] RST_LINK_TIMEOUT = 32'd500;
   localparam logic [31:0] RST_RETRY_INTVL  = 32'd200;

   typedef struct packed {
      logic [31:0] own_session;
      logic [31:0] heartbeat_interval;
      logic [31:0] link_timeout;
      logic [31:0] retry_interval;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] now_ms;
      logic        link_ok;
      logic [31:0] echoed_session;
      logic [31:0] peer_session;
      logic [31:0] exec_id;
      logic [31:0] cmd_id_in;
      logic [2:0]  step_state_in;
      logic [3:0]  failure_in;
      logic [2:0]  action;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [2:0]  step_state;
      logic [3:0]  failure_code;
      logic        send_beat;
      logic        send_cmd;
      logic        cmd_kind;
      logic [31:0] cmd_id_out;
      logic [31:0] exec_id_out;
      logic        action_out;
      logic        connected;
   } rsp_type;

   // Modular elapsed time check
   function automatic logic elapsed_ge(input logic [31:0] now, input logic [31:0] since,
                                       input logic [31:0] dur);
      logic [31:0] diff;
      diff = now - since;
      return diff >= dur;
   endfunction

   // Succeeded, failed or cancelled
   function automatic logic is_terminal(input logic [2:0] st);
      return (st == ST_SUCCEEDED) || (st == ST_FAILED) || (st == ST_CANCELLED);
   endfunction

endpackage

[rtl/rtsc_req_if.sv]
// Request and response channel interfaces of the remote task session client.
interface rtsc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [31:0] now_ms;
   logic        link_ok;
   logic [31:0] echoed_session;
   logic [31:0] peer_session;
   logic [31:0] exec_id;
   logic [31:0] cmd_id_in;
   logic [2:0]  step_state_in;
   logic [3:0]  failure_in;
   logic [2:0]  action;

   modport source (
      output valid, cmd, now_ms, link_ok, echoed_session, peer_session, exec_id,
             cmd_id_in, step_state_in, failure_in, action,
      input  ready
   );
   modport sink (
      input  valid, cmd, now_ms, link_ok, echoed_session, peer_session, exec_id,
             cmd_id_in, step_state_in, failure_in, action,
      output ready
   );
endinterface

interface rtsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [2:0]  step_state;
   logic [3:0]  failure_code;
   logic        send_beat;
   logic        send_cmd;
   logic        cmd_kind;
   logic [31:0] cmd_id_out;
   logic [31:0] exec_id_out;
   logic        action_out;
   logic        connected;

   modport source (
      output valid, ok, step_state, failure_code, send_beat, send_cmd, cmd_kind,
             cmd_id_out, exec_id_out, action_out, connected,
      input  ready
   );
   modport sink (
      input  valid, ok, step_state, failure_code, send_beat, send_cmd, cmd_kind,
             cmd_id_out, exec_id_out, action_out, connected,
      output ready
   );
endinterface

[rtl/rtsc_core.sv]
// Session and command state of the client, updated once per processed request.
module rtsc_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             proc_en,
   input  rtsc_pkg::cfg_type cfg,
   input  rtsc_pkg::req_type item,
   output rtsc_pkg::rsp_type result
);
   import rtsc_pkg::*;

   logic        peer_seen_ff, peer_seen_in;
   logic [31:0] peer_sess_ff, peer_sess_in;
   logic [31:0] prev_peer_sess_ff, prev_peer_sess_in;
   logic [31:0] last_rx_time_ff, last_rx_time_in;
   logic [31:0] last_beat_time_ff, last_beat_time_in;
   logic [31:0] last_send_time_ff, last_send_time_in;
   logic        active_ff, active_in;
   logic        cancelling_ff, cancelling_in;
   logic [31:0] next_id_ff, next_id_in;
   logic [31:0] cur_id_ff, cur_id_in;
   logic [31:0] cur_exec_ff, cur_exec_in;
   logic        cur_action_ff, cur_action_in;
   logic [2:0]  res_state_ff, res_state_in;
   logic [3:0]  res_failure_ff, res_failure_in;
   logic        fail_pending_ff, fail_pending_in;
   logic [3:0]  pending_failure_ff, pending_failure_in;

   // Work out the next state and the result of one request
   always_comb begin
      logic        take_sess;
      logic        sess_changed;
      logic        sess_stale;
      logic        send;
      logic        kind;
      logic [31:0] id_inc;

      peer_seen_in       = peer_seen_ff;
      peer_sess_in       = peer_sess_ff;
      prev_peer_sess_in  = prev_peer_sess_ff;
      last_rx_time_in    = last_rx_time_ff;
      last_beat_time_in  = last_beat_time_ff;
      last_send_time_in  = last_send_time_ff;
      active_in          = active_ff;
      cancelling_in      = cancelling_ff;
      next_id_in         = next_id_ff;
      cur_id_in          = cur_id_ff;
      cur_exec_in        = cur_exec_ff;
      cur_action_in      = cur_action_ff;
      res_state_in       = res_state_ff;
      res_failure_in     = res_failure_ff;
      fail_pending_in    = fail_pending_ff;
      pending_failure_in = pending_failure_ff;
      result             = '0;
      send               = 1'b0;
      kind               = KIND_START;
      id_inc             = next_id_ff + 32'd1;

      // Track the peer session on heartbeats and on status echoing our session
      take_sess = (item.cmd == CMD_HEARTBEAT) ||
                  ((item.cmd == CMD_STATUS) && (item.echoed_session == cfg.own_session));
      sess_changed = peer_seen_ff && (peer_sess_ff != item.peer_session);
      sess_stale   = sess_changed && (item.peer_session == prev_peer_sess_ff);

      if (take_sess && !sess_stale) begin
         if (sess_changed) begin
            prev_peer_sess_in = peer_sess_ff;
            fail_pending_in    = 1'b1;
            pending_failure_in = FL_PEER_RESET;
            if (active_ff) begin
               res_state_in   = ST_FAILED;
               res_failure_in = FL_PEER_RESET;
            end
            active_in     = 1'b0;
            cancelling_in = 1'b0;
         end
         peer_sess_in    = item.peer_session;
         peer_seen_in    = 1'b1;
         last_rx_time_in = item.now_ms;
      end

      case (item.cmd)
         CMD_TICK: begin
            if (!item.link_ok) begin
               fail_pending_in    = 1'b1;
               pending_failure_in = FL_LINK_TIMEOUT;
               if (active_ff) begin
                  res_state_in   = ST_FAILED;
                  res_failure_in = FL_LINK_TIMEOUT;
               end
            end else begin
               // heartbeat due, or never sent
               if ((last_beat_time_ff == '0) ||
                   elapsed_ge(item.now_ms, last_beat_time_ff, cfg.heartbeat_interval)) begin
                  result.send_beat  = 1'b1;
                  last_beat_time_in = item.now_ms;
               end
               // peer silent too long
               if (peer_seen_ff && elapsed_ge(item.now_ms, last_rx_time_ff, cfg.link_timeout)) begin
                  peer_seen_in       = 1'b0;
                  fail_pending_in    = 1'b1;
                  pending_failure_in = FL_LINK_TIMEOUT;
                  if (active_ff) begin
                     res_state_in   = ST_FAILED;
                     res_failure_in = FL_LINK_TIMEOUT;
                  end
               end
               // resend the active start or cancel
               if (active_ff && ((res_state_in == ST_RUNNING) || cancelling_ff) &&
                   elapsed_ge(item.now_ms, last_send_time_ff, cfg.retry_interval)) begin
                  send              = 1'b1;
                  kind              = cancelling_ff;
                  last_send_time_in = item.now_ms;
               end
            end
         end
         CMD_STATUS: begin
            if (take_sess && !sess_changed && active_ff && (item.exec_id == cur_exec_ff) &&
                (item.cmd_id_in == cur_id_ff)) begin
               if (item.step_state_in > ST_CANCELLED) begin
                  res_state_in   = ST_FAILED;
                  res_failure_in = FL_PROTOCOL;
               end else begin
                  res_state_in   = item.step_state_in;
                  res_failure_in = item.failure_in;
               end
               if (cancelling_ff && is_terminal(res_state_in)) begin
                  active_in     = 1'b0;
                  cancelling_in = 1'b0;
               end
            end
         end
         CMD_START: begin
            if (!active_ff && peer_seen_ff && (item.action <= ACT_MAX)) begin
               cur_id_in         = next_id_ff;
               next_id_in        = (id_inc == '0) ? 32'd1 : id_inc;
               cur_exec_in       = item.exec_id;
               cur_action_in     = (item.action != '0);
               res_state_in      = ST_RUNNING;
               res_failure_in    = FL_NONE;
               active_in         = 1'b1;
               cancelling_in     = 1'b0;
               last_send_time_in = item.now_ms;
               send              = 1'b1;
               kind              = KIND_START;
               result.ok         = 1'b1;
            end
         end
         CMD_POLL: begin
            if (!active_ff) begin
               result.step_state   = ST_FAILED;
               result.failure_code = FL_PROTOCOL;
            end else begin
               result.step_state   = res_state_ff;
               result.failure_code = res_failure_ff;
               if (is_terminal(res_state_ff)) begin
                  active_in = 1'b0;
               end
            end
         end
         CMD_CANCEL: begin
            if (active_ff) begin
               send              = 1'b1;
               kind              = KIND_CANCEL;
               last_send_time_in = item.now_ms;
               res_state_in      = ST_CANCELLED;
               res_failure_in    = FL_NONE;
               cancelling_in     = 1'b1;
            end
         end
         CMD_TAKE_FAIL: begin
            if (fail_pending_ff) begin
               result.ok           = 1'b1;
               result.failure_code = pending_failure_ff;
               fail_pending_in     = 1'b0;
               pending_failure_in  = FL_NONE;
            end
         end
         default: begin
            // heartbeat handled above; bad frame changes nothing
         end
      endcase

      // Fill the command fields only when a command goes out
      result.send_cmd    = send;
      result.cmd_kind    = send && kind;
      result.cmd_id_out  = send ? cur_id_in : '0;
      result.exec_id_out = send ? cur_exec_in : '0;
      result.action_out  = send && cur_action_in;
      result.connected   = peer_seen_in;
   end

   // Commit the state when a request is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         peer_seen_ff       <= 1'b0;
         peer_sess_ff       <= '0;
         prev_peer_sess_ff  <= '0;
         last_rx_time_ff    <= '0;
         last_beat_time_ff  <= '0;
         last_send_time_ff  <= '0;
         active_ff          <= 1'b0;
         cancelling_ff      <= 1'b0;
         next_id_ff         <= 32'd1;
         cur_id_ff          <= '0;
         cur_exec_ff        <= '0;
         cur_action_ff      <= 1'b0;
         res_state_ff       <= ST_NOT_STARTED;
         res_failure_ff     <= FL_NONE;
         fail_pending_ff    <= 1'b0;
         pending_failure_ff <= FL_NONE;
      end else if (proc_en) begin
         peer_seen_ff       <= peer_seen_in;
         peer_sess_ff       <= peer_sess_in;
         prev_peer_sess_ff  <= prev_peer_sess_in;
         last_rx_time_ff    <= last_rx_time_in;
         last_beat_time_ff  <= last_beat_time_in;
         last_send_time_ff  <= last_send_time_in;
         active_ff          <= active_in;
         cancelling_ff      <= cancelling_in;
         next_id_ff         <= next_id_in;
         cur_id_ff          <= cur_id_in;
         cur_exec_ff        <= cur_exec_in;
         cur_action_ff      <= cur_action_in;
         res_state_ff       <= res_state_in;
         res_failure_ff     <= res_failure_in;
         fail_pending_ff    <= fail_pending_in;
         pending_failure_ff <= pending_failure_in;
      end
   end

endmodule

[rtl/remote_task_session_client_top.sv]
// Top level of the remote task session client: request/response registers and control registers.
// A request is held in the request register, processed by the session core and registered
// in the response register, from which its response is offered on the response channel.
// Throughput: one request per cycle while responses are taken; a response that is not taken
// stalls the request register. The session state updates between the two registers.
// Reset (synchronous, active high) empties both registers, restores the control
// registers to their defaults and clears all session and command state.
module remote_task_session_client_top (
   input  logic                            clock,
   input  logic                            reset,
   rtsc_req_if.sink                        req_chan,
   rtsc_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [rtsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                     csr_wdata
);
   import rtsc_pkg::*;

   cfg_type cfg_ff;
   logic    in_valid_ff;
   req_type in_item_ff;
   logic    out_valid_ff;
   rsp_type out_item_ff;
   rsp_type core_result;
   logic    proc_en;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_session        <= RST_OWN_SESSION;
         cfg_ff.heartbeat_interval <= RST_HB_INTERVAL;
         cfg_ff.link_timeout       <= RST_LINK_TIMEOUT;
         cfg_ff.retry_interval     <= RST_RETRY_INTVL;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OWN_SESSION:  cfg_ff.own_session        <= csr_wdata;
            CSR_HB_INTERVAL:  cfg_ff.heartbeat_interval <= csr_wdata;
            CSR_LINK_TIMEOUT: cfg_ff.link_timeout       <= csr_wdata;
            CSR_RETRY_INTVL:  cfg_ff.retry_interval     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Advance the held request when the response register is free
   assign proc_en        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || proc_en;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff.cmd            <= req_chan.cmd;
         in_item_ff.now_ms         <= req_chan.now_ms;
         in_item_ff.link_ok        <= req_chan.link_ok;
         in_item_ff.echoed_session <= req_chan.echoed_session;
         in_item_ff.peer_session   <= req_chan.peer_session;
         in_item_ff.exec_id        <= req_chan.exec_id;
         in_item_ff.cmd_id_in      <= req_chan.cmd_id_in;
         in_item_ff.step_state_in  <= req_chan.step_state_in;
         in_item_ff.failure_in     <= req_chan.failure_in;
         in_item_ff.action         <= req_chan.action;
      end
   end

   rtsc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .proc_en (proc_en),
      .cfg     (cfg_ff),
      .item    (in_item_ff),
      .result  (core_result)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc_en) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_en) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.ok           = out_item_ff.ok;
   assign rsp_chan.step_state   = out_item_ff.step_state;
   assign rsp_chan.failure_code = out_item_ff.failure_code;
   assign rsp_chan.send_beat    = out_item_ff.send_beat;
   assign rsp_chan.send_cmd     = out_item_ff.send_cmd;
   assign rsp_chan.cmd_kind     = out_item_ff.cmd_kind;
   assign rsp_chan.cmd_id_out   = out_item_ff.cmd_id_out;
   assign rsp_chan.exec_id_out  = out_item_ff.exec_id_out;
   assign rsp_chan.action_out   = out_item_ff.action_out;
   assign rsp_chan.connected    = out_item_ff.connected;

   // A processed request always lands in the response register
   a_proc_to_rsp: assert property (@(posedge clock) disable iff (reset)
      proc_en |=> out_valid_ff)
      else $error("processed request did not produce a response");

   // Command ids on the wire are never zero
   a_cmd_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.send_cmd) |-> (out_item_ff.cmd_id_out != '0))
      else $error("command sent with zero id");

   // An accepted start or taken failure never carries a poll state
   a_ok_no_state: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.ok) |-> (out_item_ff.step_state == ST_NOT_STARTED))
      else $error("ok response carries a step state");

endmodule
